/* rtl/polyline_arc_length_resampler_macros.svh */
// assertion macros for the polyline arc length resampler
`ifndef POLYLINE_ARC_LENGTH_RESAMPLER_MACROS_SVH
`define POLYLINE_ARC_LENGTH_RESAMPLER_MACROS_SVH
`ifndef SYNTH
`define PLAR_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("plar assertion failed");
`define PLAR_NEVER(lbl, cond) \
   lbl: assert property (@(posedge clock) disable iff (reset) !(cond)) \
      else $error("plar forbidden condition");
`else
`define PLAR_ASSERT(lbl, prop)
`define PLAR_NEVER(lbl, cond)
`endif
`endif

/* rtl/plar_pkg.sv */
// shared types and constants for the polyline arc length resampler
`timescale 1ns / 1ps
package plar_pkg;
   localparam int COORD_W    = 20;
   localparam int MAG_W      = 20;
   localparam int LEN_W      = 21;
   localparam int SQ_W       = 42;
   localparam int SREM_W     = 23;
   localparam int ACC_W      = 22;
   localparam int STEP_W     = 16;
   localparam int NUM_W      = 42;
   localparam int ITER_W     = 5;
   localparam int SQRT_ITERS = 21;
   localparam int CNT_ITERS  = 22;
   localparam int QUOT_ITERS = 20;
   localparam int FRAC_BITS  = 8;
   localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(2 << FRAC_BITS);
   localparam int CSR_ADDR_W = 2;
   localparam logic [CSR_ADDR_W-1:0] REG_STEP_ADDR = '0;

   typedef enum logic [3:0] {
      ST_IDLE, ST_DECIDE, ST_SQX, ST_SQY, ST_SQRT, ST_ACC, ST_CNTDIV, ST_PLAN,
      ST_FIRST, ST_MUL, ST_QINIT, ST_QDIV, ST_STAMP, ST_COMMIT, ST_END
   } state_type;

   typedef enum logic [1:0] {OSEL_PREV, OSEL_CUR, OSEL_STAMP} out_sel_type;

   typedef struct packed {
      logic        latch;
      logic        start_update;
      logic        delta;
      logic        square_x;
      logic        square_y;
      logic        sqrt_step;
      logic        acc_init;
      logic        cnt_step;
      logic        plan;
      logic        plan_over;
      logic        stamp_mul;
      logic        qinit;
      logic        qstep;
      logic        commit;
      logic        end_path;
      logic        out_load;
      out_sel_type out_sel;
      logic        out_last;
   } cmd_type;

   typedef struct packed {
      logic             start;
      logic             fin;
      logic             in_path;
      logic             pending;
      logic             out_free;
      logic [ACC_W-1:0] cnt;
   } status_type;
endpackage

/* rtl/plar_dpath.sv */
// datapath: path state, segment length, stamp count and stamp interpolation
`timescale 1ns / 1ps
module plar_dpath (
   input  logic                              clock,
   input  logic                              reset,
   input  plar_pkg::cmd_type                 cmd,
   output plar_pkg::status_type              status,
   input  logic [plar_pkg::STEP_W-1:0]       step,
   input  logic signed [plar_pkg::COORD_W-1:0] in_x,
   input  logic signed [plar_pkg::COORD_W-1:0] in_y,
   input  logic                              in_start,
   input  logic                              in_end,
   output logic                              out_valid,
   input  logic                              out_ready,
   output logic signed [plar_pkg::COORD_W-1:0] out_x,
   output logic signed [plar_pkg::COORD_W-1:0] out_y,
   output logic                              out_last,
   output logic                              out_over
);
   import plar_pkg::*;

   logic signed [COORD_W-1:0] prev_x_ff, prev_x_in, prev_y_ff, prev_y_in;
   logic signed [COORD_W-1:0] cur_x_ff, cur_y_ff;
   logic cur_start_ff, cur_end_ff;
   logic [STEP_W-1:0] left_ff, left_in;
   logic in_path_ff, in_path_in, pending_ff, pending_in;
   logic [MAG_W-1:0] adx_ff, ady_ff;
   logic negx_ff, negy_ff, moved_ff;
   logic [2*MAG_W-1:0] sqx_ff;
   logic [SQ_W-1:0] rad_ff;
   logic [LEN_W-1:0] root_ff, seglen_ff;
   logic [SREM_W-1:0] srem_ff;
   logic [ACC_W-1:0] accq_ff;
   logic [STEP_W-1:0] drem_ff;
   logic [ACC_W-1:0] d_ff;
   logic [NUM_W-1:0] px_ff, py_ff;
   logic [LEN_W-1:0] rx_ff, ry_ff;
   logic [MAG_W-1:0] qx_ff, qy_ff;
   logic over_ff;
   logic ov_ff, ov_in;
   logic signed [COORD_W-1:0] ox_ff, oy_ff, ox_in, oy_in;
   logic olast_ff, olast_in;
   logic oover_ff, oover_in;

   logic [STEP_W-1:0] stp;
   logic signed [COORD_W:0] dx, dy;
   logic [COORD_W:0] dxa, dya;
   logic [SREM_W+1:0] srem2, trial;
   logic [STEP_W:0] drem2;
   logic [NUM_W-1:0] numx, numy;
   logic [LEN_W:0] tx, ty;
   logic [COORD_W+1:0] sx, sy;
   logic out_free;

   assign stp = (step == '0) ? STEP_W'(1) : step;
   assign dx = {cur_x_ff[COORD_W-1], cur_x_ff} - {prev_x_ff[COORD_W-1], prev_x_ff};
   assign dy = {cur_y_ff[COORD_W-1], cur_y_ff} - {prev_y_ff[COORD_W-1], prev_y_ff};
   assign dxa = dx[COORD_W] ? (COORD_W+1)'(0) - dx : dx;
   assign dya = dy[COORD_W] ? (COORD_W+1)'(0) - dy : dy;
   assign srem2 = {srem_ff, rad_ff[SQ_W-1 -: 2]};
   assign trial = (SREM_W+2)'({root_ff, 2'b01});
   assign drem2 = {drem_ff, accq_ff[ACC_W-1]};
   assign numx = px_ff + NUM_W'(seglen_ff >> 1);
   assign numy = py_ff + NUM_W'(seglen_ff >> 1);
   assign tx = {rx_ff, qx_ff[MAG_W-1]};
   assign ty = {ry_ff, qy_ff[MAG_W-1]};
   assign sx = {{2{prev_x_ff[COORD_W-1]}}, prev_x_ff}
             + (negx_ff ? (COORD_W+2)'(0) - (COORD_W+2)'(qx_ff) : (COORD_W+2)'(qx_ff));
   assign sy = {{2{prev_y_ff[COORD_W-1]}}, prev_y_ff}
             + (negy_ff ? (COORD_W+2)'(0) - (COORD_W+2)'(qy_ff) : (COORD_W+2)'(qy_ff));
   assign out_free = !ov_ff || out_ready;

   assign status.start    = cur_start_ff;
   assign status.fin      = cur_end_ff;
   assign status.in_path  = in_path_ff;
   assign status.pending  = pending_ff;
   assign status.out_free = out_free;
   assign status.cnt      = accq_ff;

   always_comb begin
      prev_x_in = prev_x_ff;
      prev_y_in = prev_y_ff;
      left_in = left_ff;
      in_path_in = in_path_ff;
      pending_in = pending_ff;
      if (cmd.start_update) begin
         prev_x_in = cur_x_ff;
         prev_y_in = cur_y_ff;
         left_in = '0;
         in_path_in = !cur_end_ff;
         pending_in = !cur_end_ff;
      end
      if (cmd.plan) pending_in = 1'b0;
      if (cmd.commit && moved_ff) begin
         prev_x_in = cur_x_ff;
         prev_y_in = cur_y_ff;
         left_in = drem_ff;
      end
      if (cmd.end_path) in_path_in = 1'b0;
   end

   always_comb begin
      ov_in = ov_ff;
      ox_in = ox_ff;
      oy_in = oy_ff;
      olast_in = olast_ff;
      oover_in = oover_ff;
      if (out_ready) ov_in = 1'b0;
      if (cmd.out_load) begin
         ov_in = 1'b1;
         olast_in = cmd.out_last;
         oover_in = over_ff;
         case (cmd.out_sel)
            OSEL_PREV: begin
               ox_in = prev_x_ff;
               oy_in = prev_y_ff;
            end
            OSEL_CUR: begin
               ox_in = cur_x_ff;
               oy_in = cur_y_ff;
            end
            OSEL_STAMP: begin
               ox_in = sx[COORD_W-1:0];
               oy_in = sy[COORD_W-1:0];
            end
            default: begin
               ox_in = cur_x_ff;
               oy_in = cur_y_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_x_ff <= '0;
         prev_y_ff <= '0;
         left_ff <= '0;
         in_path_ff <= 1'b0;
         pending_ff <= 1'b0;
         ov_ff <= 1'b0;
      end else begin
         prev_x_ff <= prev_x_in;
         prev_y_ff <= prev_y_in;
         left_ff <= left_in;
         in_path_ff <= in_path_in;
         pending_ff <= pending_in;
         ov_ff <= ov_in;
      end
   end

   always_ff @(posedge clock) begin
      ox_ff <= ox_in;
      oy_ff <= oy_in;
      olast_ff <= olast_in;
      oover_ff <= oover_in;
      if (cmd.latch) begin
         cur_x_ff <= in_x;
         cur_y_ff <= in_y;
         cur_start_ff <= in_start;
         cur_end_ff <= in_end;
      end
      if (cmd.delta) begin
         adx_ff <= dxa[MAG_W-1:0];
         ady_ff <= dya[MAG_W-1:0];
         negx_ff <= dx[COORD_W];
         negy_ff <= dy[COORD_W];
         moved_ff <= (dx != '0) || (dy != '0);
      end
      if (cmd.square_x) sqx_ff <= adx_ff * adx_ff;
      if (cmd.square_y) begin
         rad_ff <= SQ_W'(sqx_ff) + SQ_W'(ady_ff * ady_ff);
         root_ff <= '0;
         srem_ff <= '0;
      end
      if (cmd.sqrt_step) begin
         rad_ff <= {rad_ff[SQ_W-3:0], 2'b00};
         if (srem2 >= trial) begin
            srem_ff <= SREM_W'(srem2 - trial);
            root_ff <= {root_ff[LEN_W-2:0], 1'b1};
         end else begin
            srem_ff <= SREM_W'(srem2);
            root_ff <= {root_ff[LEN_W-2:0], 1'b0};
         end
      end
      if (cmd.acc_init) begin
         seglen_ff <= root_ff;
         accq_ff <= moved_ff ? ACC_W'(left_ff) + ACC_W'(root_ff) : '0;
         drem_ff <= '0;
      end
      if (cmd.cnt_step) begin
         if (drem2 >= {1'b0, stp}) begin
            drem_ff <= STEP_W'(drem2 - {1'b0, stp});
            accq_ff <= {accq_ff[ACC_W-2:0], 1'b1};
         end else begin
            drem_ff <= drem2[STEP_W-1:0];
            accq_ff <= {accq_ff[ACC_W-2:0], 1'b0};
         end
      end
      if (cmd.plan) begin
         over_ff <= cmd.plan_over;
         d_ff <= ACC_W'(stp) - ACC_W'(left_ff);
      end
      if (cmd.stamp_mul) begin
         px_ff <= NUM_W'(adx_ff * d_ff[LEN_W-1:0]);
         py_ff <= NUM_W'(ady_ff * d_ff[LEN_W-1:0]);
         d_ff <= d_ff + ACC_W'(stp);
      end
      if (cmd.qinit) begin
         rx_ff <= numx[NUM_W-2 -: LEN_W];
         ry_ff <= numy[NUM_W-2 -: LEN_W];
         qx_ff <= numx[MAG_W-1:0];
         qy_ff <= numy[MAG_W-1:0];
      end
      if (cmd.qstep) begin
         if (tx >= {1'b0, seglen_ff}) begin
            rx_ff <= LEN_W'(tx - {1'b0, seglen_ff});
            qx_ff <= {qx_ff[MAG_W-2:0], 1'b1};
         end else begin
            rx_ff <= tx[LEN_W-1:0];
            qx_ff <= {qx_ff[MAG_W-2:0], 1'b0};
         end
         if (ty >= {1'b0, seglen_ff}) begin
            ry_ff <= LEN_W'(ty - {1'b0, seglen_ff});
            qy_ff <= {qy_ff[MAG_W-2:0], 1'b1};
         end else begin
            ry_ff <= ty[LEN_W-1:0];
            qy_ff <= {qy_ff[MAG_W-2:0], 1'b0};
         end
      end
   end

   assign out_valid = ov_ff;
   assign out_x = ox_ff;
   assign out_y = oy_ff;
   assign out_last = olast_ff;
   assign out_over = oover_ff;
endmodule

/* rtl/plar_ctrl.sv */
// controller: sequences segment length, stamp count and stamp emission
`timescale 1ns / 1ps
`include "polyline_arc_length_resampler_macros.svh"
module plar_ctrl #(
   parameter int MAX_RESULTS = 64
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  plar_pkg::status_type status,
   output plar_pkg::cmd_type    cmd
);
   import plar_pkg::*;

   localparam int CNT_W = $clog2(MAX_RESULTS + 1);
   localparam logic [CNT_W-1:0] MAX_C = CNT_W'(MAX_RESULTS);
   localparam logic [ACC_W:0] MAX_W = (ACC_W+1)'(MAX_RESULTS);

   state_type state_ff, state_in;
   logic [ITER_W-1:0] iter_ff, iter_in;
   logic [CNT_W-1:0] nseg_ff, nseg_in, emit_ff, emit_in, nemit_ff, nemit_in;
   logic end_emit_ff, end_emit_in;

   logic [CNT_W-1:0] room, nseg_calc;
   logic [ACC_W:0] total, end_need;
   logic end_fit, last;

   always_comb begin
      room = MAX_C - CNT_W'(status.pending);
      nseg_calc = (status.cnt <= ACC_W'(room)) ? status.cnt[CNT_W-1:0] : room;
      total = (ACC_W+1)'(status.cnt) + (ACC_W+1)'(status.pending)
            + (ACC_W+1)'(status.fin);
      end_need = (ACC_W+1)'(status.cnt) + (ACC_W+1)'(status.pending) + (ACC_W+1)'(1);
      end_fit = status.fin && (end_need <= MAX_W);
      last = (emit_ff + CNT_W'(1)) == nemit_ff;
   end

   always_comb begin
      state_in = state_ff;
      iter_in = '0;
      nseg_in = nseg_ff;
      emit_in = emit_ff;
      nemit_in = nemit_ff;
      end_emit_in = end_emit_ff;
      cmd = '0;
      cmd.out_sel = OSEL_PREV;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.latch = 1'b1;
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            cmd.delta = 1'b1;
            if (status.start) begin
               cmd.start_update = 1'b1;
               state_in = ST_IDLE;
            end else if (!status.in_path) begin
               state_in = ST_IDLE;
            end else begin
               state_in = ST_SQX;
            end
         end
         ST_SQX: begin
            cmd.square_x = 1'b1;
            state_in = ST_SQY;
         end
         ST_SQY: begin
            cmd.square_y = 1'b1;
            state_in = ST_SQRT;
         end
         ST_SQRT: begin
            cmd.sqrt_step = 1'b1;
            iter_in = iter_ff + ITER_W'(1);
            if (iter_ff == ITER_W'(SQRT_ITERS - 1)) state_in = ST_ACC;
         end
         ST_ACC: begin
            cmd.acc_init = 1'b1;
            state_in = ST_CNTDIV;
         end
         ST_CNTDIV: begin
            cmd.cnt_step = 1'b1;
            iter_in = iter_ff + ITER_W'(1);
            if (iter_ff == ITER_W'(CNT_ITERS - 1)) state_in = ST_PLAN;
         end
         ST_PLAN: begin
            cmd.plan = 1'b1;
            cmd.plan_over = total > MAX_W;
            nseg_in = nseg_calc;
            end_emit_in = end_fit;
            emit_in = '0;
            nemit_in = CNT_W'(status.pending) + nseg_calc + CNT_W'(end_fit);
            if (status.pending) state_in = ST_FIRST;
            else if (nseg_calc != '0) state_in = ST_MUL;
            else state_in = ST_COMMIT;
         end
         ST_FIRST: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_sel = OSEL_PREV;
               cmd.out_last = last;
               emit_in = emit_ff + CNT_W'(1);
               state_in = (nseg_ff != '0) ? ST_MUL : ST_COMMIT;
            end
         end
         ST_MUL: begin
            cmd.stamp_mul = 1'b1;
            state_in = ST_QINIT;
         end
         ST_QINIT: begin
            cmd.qinit = 1'b1;
            state_in = ST_QDIV;
         end
         ST_QDIV: begin
            cmd.qstep = 1'b1;
            iter_in = iter_ff + ITER_W'(1);
            if (iter_ff == ITER_W'(QUOT_ITERS - 1)) state_in = ST_STAMP;
         end
         ST_STAMP: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_sel = OSEL_STAMP;
               cmd.out_last = last;
               emit_in = emit_ff + CNT_W'(1);
               nseg_in = nseg_ff - CNT_W'(1);
               state_in = (nseg_ff == CNT_W'(1)) ? ST_COMMIT : ST_MUL;
            end
         end
         ST_COMMIT: begin
            cmd.commit = 1'b1;
            cmd.end_path = status.fin;
            state_in = end_emit_ff ? ST_END : ST_IDLE;
         end
         ST_END: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_sel = OSEL_CUR;
               cmd.out_last = last;
               emit_in = emit_ff + CNT_W'(1);
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         iter_ff <= '0;
         nseg_ff <= '0;
         emit_ff <= '0;
         nemit_ff <= '0;
         end_emit_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         iter_ff <= iter_in;
         nseg_ff <= nseg_in;
         emit_ff <= emit_in;
         nemit_ff <= nemit_in;
         end_emit_ff <= end_emit_in;
      end
   end

   `PLAR_NEVER(a_emit_limit, emit_ff > MAX_C)
   `PLAR_ASSERT(a_load_free, cmd.out_load |-> status.out_free)
   `PLAR_ASSERT(a_sqrt_exit, state_ff == ST_SQRT |=> state_ff == ST_SQRT || state_ff == ST_ACC)
   `PLAR_NEVER(a_emit_over_plan, cmd.out_load && emit_ff >= nemit_ff)
endmodule

/* rtl/polyline_arc_length_resampler.sv */
// top level of the polyline arc length resampler
// usage:
//   req channel carries path points; tuser marks the first point of a path,
//   tlast the final one. rsp channel carries stamp positions; tlast marks the
//   last stamp caused by one point, tuser flags a point whose stamps were cut
//   at MAX_RESULTS. csr port holds the stamp spacing at address 0 (reset 2.0).
// timing:
//   one point is taken at a time; req_tready is high only while idle.
//   a start point or a point outside a path is latched, then decided upon.
//   a path point is latched, decided, squared in x and y, square-rooted,
//   accumulated, passed through the stamp count divide and planned; then
//   come the first stamp, per interpolated stamp a multiply, divide setup,
//   bit-serial divide of both coordinates and emit, the commit, the end stamp.
//   results sit in an output register; a stalled receiver holds the
//   controller in its emit state with no item lost.
// reset: synchronous; clears path state, step returns to 2.0, no rsp item.
`timescale 1ns / 1ps
module polyline_arc_length_resampler #(
   parameter int MAX_RESULTS = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // point_x, point_y
   input  logic        req_tuser,   // path_start
   input  logic        req_tlast,   // path_end
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // stamp_x, stamp_y
   output logic        rsp_tuser,   // overflow
   output logic        rsp_tlast,   // last_of_run
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [plar_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import plar_pkg::*;

   logic [STEP_W-1:0] step_ff, step_in;
   cmd_type cmd;
   status_type status;
   logic signed [COORD_W-1:0] out_x, out_y;

   always_comb begin
      step_in = step_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_paddr == REG_STEP_ADDR)
         step_in = csr_pwdata[STEP_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) step_ff <= STEP_RESET;
      else step_ff <= step_in;
   end

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == REG_STEP_ADDR) ? 32'(step_ff) : '0;

   plar_ctrl #(.MAX_RESULTS(MAX_RESULTS)) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .status    (status),
      .cmd       (cmd)
   );

   plar_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .step      (step_ff),
      .in_x      (req_tdata[19:0]),
      .in_y      (req_tdata[39:20]),
      .in_start  (req_tuser),
      .in_end    (req_tlast),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_x     (out_x),
      .out_y     (out_y),
      .out_last  (rsp_tlast),
      .out_over  (rsp_tuser)
   );

   assign rsp_tdata = {out_y, out_x};
endmodule
